// ===== rtl/core/iad_pkg.sv =====
// ----------------------------------------------------------------------------
// iad_pkg: shared definitions for the integer to ascii digit converter
// command codes, microcode word layout, program rom and digit character table
// ----------------------------------------------------------------------------
package iad_pkg;

    // conversion commands
    localparam logic [2:0] CMD_SDEC32  = 3'd0;
    localparam logic [2:0] CMD_UDEC32  = 3'd1;
    localparam logic [2:0] CMD_HEX32L  = 3'd2;
    localparam logic [2:0] CMD_HEX32U  = 3'd3;
    localparam logic [2:0] CMD_HEX64L  = 3'd4;

    localparam int DIGITS_MAX = 16;

    // magic reciprocal: floor(x / 10) == (x * RECIP10) >> RECIP10_SHIFT for 32-bit x
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;

    // datapath operations
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_DIGIT = 3'd3;
    localparam logic [2:0] OP_FETCH = 3'd4;
    localparam logic [2:0] OP_SEND  = 3'd5;

    // branch conditions
    localparam logic [2:0] COND_ALWAYS   = 3'd0;
    localparam logic [2:0] COND_IN_OK    = 3'd1;
    localparam logic [2:0] COND_MORE     = 3'd2;
    localparam logic [2:0] COND_OUT_FIRE = 3'd3;
    localparam logic [2:0] COND_EMIT     = 3'd4;

    // program steps
    localparam logic [2:0] STEP_IDLE  = 3'd0;
    localparam logic [2:0] STEP_MUL   = 3'd1;
    localparam logic [2:0] STEP_DIGIT = 3'd2;
    localparam logic [2:0] STEP_FETCH = 3'd3;
    localparam logic [2:0] STEP_SEND  = 3'd4;
    localparam logic [2:0] STEP_NEXT  = 3'd5;

    typedef struct packed {
        logic       in_ready;
        logic       out_valid;
        logic [2:0] op;
        logic [2:0] cond;
        logic [2:0] tgt_true;
        logic [2:0] tgt_false;
    } ctrl_t;

    // microcode rom
    function automatic ctrl_t ucode(input logic [2:0] step);
        ctrl_t w;
        w = '{in_ready: 1'b0, out_valid: 1'b0, op: OP_NONE, cond: COND_ALWAYS,
              tgt_true: STEP_IDLE, tgt_false: STEP_IDLE};
        case (step)
            STEP_IDLE:
            begin
                w = '{1'b1, 1'b0, OP_LOAD, COND_IN_OK, STEP_MUL, STEP_IDLE};
            end
            STEP_MUL:
            begin
                w = '{1'b0, 1'b0, OP_MUL, COND_ALWAYS, STEP_DIGIT, STEP_DIGIT};
            end
            STEP_DIGIT:
            begin
                w = '{1'b0, 1'b0, OP_DIGIT, COND_MORE, STEP_MUL, STEP_FETCH};
            end
            STEP_FETCH:
            begin
                w = '{1'b0, 1'b0, OP_FETCH, COND_ALWAYS, STEP_SEND, STEP_SEND};
            end
            STEP_SEND:
            begin
                w = '{1'b0, 1'b1, OP_SEND, COND_OUT_FIRE, STEP_NEXT, STEP_SEND};
            end
            STEP_NEXT:
            begin
                w = '{1'b0, 1'b0, OP_NONE, COND_EMIT, STEP_FETCH, STEP_IDLE};
            end
            default:
            begin
                w = '{1'b0, 1'b0, OP_NONE, COND_ALWAYS, STEP_IDLE, STEP_IDLE};
            end
        endcase
        return w;
    endfunction

    localparam logic [6:0] DIGIT_LOWER [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
    };
    localparam logic [6:0] DIGIT_UPPER [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
    };

    function automatic logic [6:0] digit_to_char(input logic [3:0] d, input logic upper);
        return upper ? DIGIT_UPPER[d] : DIGIT_LOWER[d];
    endfunction

endpackage

// ===== rtl/core/iad_if.sv =====
// ----------------------------------------------------------------------------
// iad channel interfaces
// command beats in, digit beats out, valid/ready handshake
// ----------------------------------------------------------------------------
interface iad_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [63:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface iad_dig_if;
    logic       valid;
    logic       ready;
    logic [6:0] digit_char;
    logic [3:0] digit_index;
    logic       last_digit;
    logic       negative;

    modport source (output valid, output digit_char, output digit_index,
                    output last_digit, output negative, input ready);
    modport sink   (input valid, input digit_char, input digit_index,
                    input last_digit, input negative, output ready);
endinterface

// ===== rtl/core/integer_to_ascii_digits.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_digits: binary to ascii decimal / hex digit converter
// microcoded sequencer: rom word per step drives a small digit datapath
// ----------------------------------------------------------------------------
// sequence: a command is accepted in the idle step, then each digit is collected
//   by a reciprocal multiply step and a digit extract step, then each digit is fetched and offered
// throughput: one command at a time, set by the program loop (2 steps per digit
//   collected, 3 steps per digit emitted, the send step waiting on the sink);
//   undefined commands are accepted and dropped with no beats
// reset: rst_n asynchronous active low, sequencer returns to the idle step
// ----------------------------------------------------------------------------
module integer_to_ascii_digits (
    input  logic          clk,
    input  logic          rst_n,
    iad_cmd_if.sink       cmd,
    iad_dig_if.source     digits
);

    iad_pkg::ctrl_t ctrl;

    // sequencer
    logic [2:0]  step_reg;
    logic [2:0]  step_next;
    logic        cond_true;

    // datapath state
    logic [63:0] val_reg;
    logic [63:0] prod_reg;
    logic        hex_reg;
    logic        upper_reg;
    logic        neg_reg;
    logic [4:0]  n_reg;
    logic [4:0]  k_reg;
    logic [3:0]  digit_buf [iad_pkg::DIGITS_MAX];

    // output register
    logic [6:0]  char_reg;
    logic [3:0]  idx_reg;
    logic        last_reg;

    // handshakes
    logic        in_fire;
    logic        out_fire;
    logic        cmd_ok;

    // load path
    logic [31:0] low_word;
    logic        load_neg;
    logic [63:0] load_val;

    // digit path
    logic [28:0] quot;
    logic [3:0]  q10_lo;
    logic [3:0]  digit_val;
    logic [63:0] val_next;
    logic [4:0]  n_inc;
    logic        more;
    logic [3:0]  rd_addr;

    assign ctrl     = iad_pkg::ucode(step_reg);
    assign in_fire  = cmd.valid && ctrl.in_ready;
    assign out_fire = ctrl.out_valid && digits.ready;

    assign cmd.ready          = ctrl.in_ready;
    assign digits.valid       = ctrl.out_valid;
    assign digits.digit_char  = char_reg;
    assign digits.digit_index = idx_reg;
    assign digits.last_digit  = last_reg;
    assign digits.negative    = neg_reg;

    // command decode and operand conditioning
    always_comb
    begin
        low_word = cmd.value[31:0];
        cmd_ok   = cmd.command inside {iad_pkg::CMD_SDEC32, iad_pkg::CMD_UDEC32,
                                       iad_pkg::CMD_HEX32L, iad_pkg::CMD_HEX32U,
                                       iad_pkg::CMD_HEX64L};
        load_neg = (cmd.command == iad_pkg::CMD_SDEC32) && low_word[31];
        if (cmd.command == iad_pkg::CMD_HEX64L)
        begin
            load_val = cmd.value;
        end
        else if (load_neg)
        begin
            // most negative value wraps to 2^31, which is the right magnitude
            load_val = {32'd0, 32'(32'd0 - low_word)};
        end
        else
        begin
            load_val = {32'd0, low_word};
        end
    end

    // one digit: hex is a nibble shift, decimal uses the registered product
    always_comb
    begin
        quot    = prod_reg[63:iad_pkg::RECIP10_SHIFT];
        // low nibble of quot*10 is enough, the remainder is below 10
        q10_lo  = 4'({quot[0], 3'b000} + {quot[2:0], 1'b0});
        if (hex_reg)
        begin
            digit_val = val_reg[3:0];
            val_next  = {4'd0, val_reg[63:4]};
        end
        else
        begin
            digit_val = 4'(val_reg[3:0] - q10_lo);
            val_next  = {35'd0, quot};
        end
        n_inc = n_reg + 5'd1;
        more  = (val_next != 64'd0) && (n_inc < 5'(iad_pkg::DIGITS_MAX));
    end

    // digits were stored least significant first, read back from the top
    assign rd_addr = 4'(n_reg - 5'd1 - k_reg);

    // branch condition select
    always_comb
    begin
        case (ctrl.cond)
            iad_pkg::COND_ALWAYS:   cond_true = 1'b1;
            iad_pkg::COND_IN_OK:    cond_true = in_fire && cmd_ok;
            iad_pkg::COND_MORE:     cond_true = more;
            iad_pkg::COND_OUT_FIRE: cond_true = out_fire;
            iad_pkg::COND_EMIT:     cond_true = (k_reg != n_reg);
            default:                cond_true = 1'b0;
        endcase
        step_next = cond_true ? ctrl.tgt_true : ctrl.tgt_false;
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= iad_pkg::STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // datapath, driven by the current control word
    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            iad_pkg::OP_LOAD:
            begin
                if (in_fire)
                begin
                    val_reg   <= load_val;
                    hex_reg   <= cmd.command inside {iad_pkg::CMD_HEX32L,
                                                     iad_pkg::CMD_HEX32U,
                                                     iad_pkg::CMD_HEX64L};
                    upper_reg <= (cmd.command == iad_pkg::CMD_HEX32U);
                    neg_reg   <= load_neg;
                    n_reg     <= 5'd0;
                    k_reg     <= 5'd0;
                end
            end
            iad_pkg::OP_MUL:
            begin
                prod_reg <= 64'(val_reg[31:0]) * 64'(iad_pkg::RECIP10);
            end
            iad_pkg::OP_DIGIT:
            begin
                digit_buf[n_reg[3:0]] <= digit_val;
                val_reg               <= val_next;
                n_reg                 <= n_inc;
            end
            iad_pkg::OP_FETCH:
            begin
                char_reg <= iad_pkg::digit_to_char(digit_buf[rd_addr], upper_reg);
                idx_reg  <= k_reg[3:0];
                last_reg <= ((k_reg + 5'd1) == n_reg);
            end
            iad_pkg::OP_SEND:
            begin
                if (out_fire)
                begin
                    k_reg <= k_reg + 5'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for integer_to_ascii_digits
// drives command beats with random gaps, predicts every digit beat of each
// conversion and compares the digit stream field by field, with random and
// long back-pressure on the digit side
// ----------------------------------------------------------------------------
module tb;

    // undefined command codes, the block drops these without a digit beat
    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    localparam int RANDOM_COMMANDS = 350;
    localparam int HOLD_CYCLES     = 300;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT  = 4000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES    = 20;    // covers a dropped command in flight

    // one digit beat as seen on the output channel
    typedef struct packed {
        logic [6:0] digit_char;
        logic [3:0] digit_index;
        logic       last_digit;
        logic       negative;
    } digit_beat_t;

    // ------------------------------------------------------------------------
    // digit stream scoreboard: expands each accepted command into its digits
    // ------------------------------------------------------------------------
    class digit_scoreboard;
        digit_beat_t expected_digits[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("mismatch @%0t: %s", $time, msg);
            errors++;
        endtask

        function logic [6:0] to_ascii(logic [3:0] d, logic upper);
            if (d < 4'd10)
                return 7'h30 + 7'(d);
            return (upper ? 7'h41 : 7'h61) + 7'(d) - 7'd10;
        endfunction

        function int pending();
            return expected_digits.size();
        endfunction

        // conversion model: collect digits lsd first, queue them msd first
        function void note_command(logic [2:0] command, logic [63:0] value);
            logic [63:0] mag;
            logic [63:0] radix;
            logic [31:0] low_word;
            logic        neg;
            logic        upper;
            logic [3:0]  lsd_first [16];
            int          n;
            digit_beat_t beat;

            neg = 1'b0;
            upper = 1'b0;
            radix = 64'd16;
            low_word = value[31:0];
            mag = {32'd0, low_word};
            case (command)
                iad_pkg::CMD_SDEC32:
                begin
                    radix = 64'd10;
                    if (low_word[31])
                    begin
                        // two's complement magnitude, min value stays 2^31
                        neg = 1'b1;
                        low_word = 32'd0 - low_word;
                        mag = {32'd0, low_word};
                    end
                end
                iad_pkg::CMD_UDEC32:
                begin
                    radix = 64'd10;
                end
                iad_pkg::CMD_HEX32L:
                begin
                end
                iad_pkg::CMD_HEX32U:
                begin
                    upper = 1'b1;
                end
                iad_pkg::CMD_HEX64L:
                begin
                    mag = value;
                end
                default:
                begin
                    return;
                end
            endcase

            n = 0;
            do
            begin
                lsd_first[n] = 4'(mag % radix);
                mag = mag / radix;
                n++;
            end
            while (mag != 0 && n < iad_pkg::DIGITS_MAX);

            for (int k = 0; k < n; k++)
            begin
                beat.digit_char  = to_ascii(lsd_first[n - 1 - k], upper);
                beat.digit_index = 4'(k);
                beat.last_digit  = (k == n - 1);
                beat.negative    = neg;
                expected_digits.push_back(beat);
            end
        endfunction

        task check_digit(digit_beat_t got);
            digit_beat_t want;
            if (expected_digits.size() == 0)
            begin
                report($sformatf("digit beat char=%h idx=%0d with nothing expected",
                                 got.digit_char, got.digit_index));
                return;
            end
            want = expected_digits.pop_front();
            if (got.digit_char !== want.digit_char)
                report($sformatf("digit_char %h, expected %h (idx %0d)",
                                 got.digit_char, want.digit_char, want.digit_index));
            if (got.digit_index !== want.digit_index)
                report($sformatf("digit_index %0d, expected %0d",
                                 got.digit_index, want.digit_index));
            if (got.last_digit !== want.last_digit)
                report($sformatf("last_digit %b, expected %b (idx %0d)",
                                 got.last_digit, want.last_digit, want.digit_index));
            if (got.negative !== want.negative)
                report($sformatf("negative %b, expected %b (idx %0d)",
                                 got.negative, want.negative, want.digit_index));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    iad_cmd_if cmd_ch ();
    iad_dig_if dig_ch ();

    integer_to_ascii_digits dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch.sink),
        .digits (dig_ch.source)
    );

    digit_scoreboard sb = new();

    // idle knobs, changed by the stimulus between segments
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    bit hold_request  = 1'b0;

    // gap length: none unless the idle percentage is hit, then mostly short, a few long
    function automatic int pick_gap(int pct);
        if (int'($urandom_range(99)) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return int'($urandom_range(40, 15));
        return int'($urandom_range(3, 1));
    endfunction

    // ------------------------------------------------------------------------
    // command side: idle for a gap, offer one beat, hold until it is taken
    // ------------------------------------------------------------------------
    task automatic send_command(logic [2:0] command, logic [63:0] value);
        int gap;
        gap = pick_gap(src_idle_pct);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= command;
        cmd_ch.value   <= value;
        // pre-edge values at the edge decide the handshake
        do
            @(posedge clk);
        while (!(cmd_ch.valid && cmd_ch.ready));
        sb.note_command(command, value);
    endtask

    // random value shaped so that every digit count shows up
    function automatic logic [63:0] random_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(4))
            0: return v;                                   // full width
            1: return v >> $urandom_range(63);             // any digit count
            2: return 64'($urandom_range(20));             // tiny, zero included
            3: return 64'd0 - 64'($urandom_range(1, 20));   // small negative
            default: return {v[63:32], 32'h8000_0000 ^ v[31:0]};
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // digit side: sample the beat, then pick ready for the next cycle
    // ------------------------------------------------------------------------
    initial
    begin : digit_sink
        int stall_left;
        digit_beat_t got;
        stall_left = 0;
        dig_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (dig_ch.valid && dig_ch.ready)
            begin
                got.digit_char  = dig_ch.digit_char;
                got.digit_index = dig_ch.digit_index;
                got.last_digit  = dig_ch.last_digit;
                got.negative    = dig_ch.negative;
                sb.check_digit(got);
            end
            if (hold_request)
            begin
                // long hold-off so the block backs up into the command side
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0)
                stall_left = pick_gap(sink_idle_pct);
            if (stall_left > 0)
            begin
                dig_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                dig_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without a beat on either side ends the run
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (dig_ch.valid && dig_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: %0d expected digits outstanding", sb.pending());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int accepted;
        logic [2:0] command;

        cmd_ch.valid   <= 1'b0;
        cmd_ch.command <= iad_pkg::CMD_SDEC32;
        cmd_ch.value   <= 64'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero in every mode, extremes, sign handling
        send_command(iad_pkg::CMD_SDEC32, 64'd0);
        send_command(iad_pkg::CMD_UDEC32, 64'd0);
        send_command(iad_pkg::CMD_HEX32L, 64'd0);
        send_command(iad_pkg::CMD_HEX32U, 64'd0);
        send_command(iad_pkg::CMD_HEX64L, 64'd0);
        send_command(iad_pkg::CMD_SDEC32, 64'h0000_0000_7FFF_FFFF);
        send_command(iad_pkg::CMD_SDEC32, 64'h0000_0000_8000_0000);   // most negative
        send_command(iad_pkg::CMD_SDEC32, 64'hFFFF_FFFF_FFFF_FFFF);   // minus one
        send_command(iad_pkg::CMD_SDEC32, 64'h1234_5678_FFFF_FFF6);   // upper bits ignored
        send_command(iad_pkg::CMD_UDEC32, 64'h0000_0000_FFFF_FFFF);
        send_command(iad_pkg::CMD_UDEC32, 64'hFFFF_FFFF_0000_000A);   // upper bits ignored
        send_command(iad_pkg::CMD_UDEC32, 64'd9);
        send_command(iad_pkg::CMD_HEX32L, 64'hFFFF_FFFF_DEAD_BEEF);
        send_command(iad_pkg::CMD_HEX32L, 64'h0000_0000_0000_000F);
        send_command(iad_pkg::CMD_HEX32U, 64'h0000_0001_ABCD_EF12);
        send_command(iad_pkg::CMD_HEX32U, 64'h0000_0000_FFFF_FFFF);
        send_command(iad_pkg::CMD_HEX64L, 64'hFFFF_FFFF_FFFF_FFFF);   // all 16 digits
        send_command(iad_pkg::CMD_HEX64L, 64'h8000_0000_0000_0000);
        send_command(iad_pkg::CMD_HEX64L, 64'h0000_0001_0000_0000);
        // undefined codes produce nothing, the stream must continue cleanly
        send_command(CMD_RSVD5, 64'h0000_0000_0000_0005);
        send_command(CMD_RSVD6, 64'hFFFF_FFFF_FFFF_FFFF);
        send_command(CMD_RSVD7, 64'd0);
        send_command(iad_pkg::CMD_UDEC32, 64'd10);

        // random: segments of differing idle mix, first one under back-pressure
        accepted = 0;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_request  = 1'b1;
        while (accepted < RANDOM_COMMANDS)
        begin
            if (accepted % 50 == 0 && accepted != 0)
            begin
                case ($urandom_range(2))
                    0: src_idle_pct = 0;
                    1: src_idle_pct = 20;
                    default: src_idle_pct = 60;
                endcase
                case ($urandom_range(2))
                    0: sink_idle_pct = 0;
                    1: sink_idle_pct = 25;
                    default: sink_idle_pct = 60;
                endcase
            end
            if ($urandom_range(19) == 0)
                command = 3'($urandom_range(CMD_RSVD7, CMD_RSVD5));
            else
            begin
                command = 3'($urandom_range(iad_pkg::CMD_HEX64L, iad_pkg::CMD_SDEC32));
                accepted++;
            end
            send_command(command, random_value());
        end
        cmd_ch.valid <= 1'b0;

        // drain: every digit in, then a few quiet cycles for stray beats
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/iad_pkg.sv
rtl/core/iad_if.sv
rtl/core/integer_to_ascii_digits.sv
dv/tb.sv
